[rtl/tab_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tab_pkg
// Shared types and constants of the averaging bang-bang thermostat.
// ----------------------------------------------------------------------------
package tab_pkg;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_UP     = 2'd1,
      MODE_DOWN   = 2'd2,
      MODE_TOGGLE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_SETPOINT_MIN     = 3'd0,
      CSR_SETPOINT_MAX     = 3'd1,
      CSR_SETPOINT_STEP    = 3'd2,
      CSR_SETPOINT_DEFAULT = 3'd3,
      CSR_SWITCH_OFFSET    = 3'd4
   } csr_index_type;

   localparam int unsigned MODE_W     = 2;
   localparam int unsigned RAW_W      = 8;
   localparam int unsigned SETPOINT_W = 7;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned OFFSET_W   = 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 7;
   localparam int unsigned TEMP_W     = 8;
   localparam int unsigned SUM_W      = 12;
   localparam int unsigned COUNT_W    = 4;

   localparam logic [SETPOINT_W-1:0] SETPOINT_MIN_RST     = 7'd35;
   localparam logic [SETPOINT_W-1:0] SETPOINT_MAX_RST     = 7'd75;
   localparam logic [STEP_W-1:0]     SETPOINT_STEP_RST    = 4'd5;
   localparam logic [SETPOINT_W-1:0] SETPOINT_DEFAULT_RST = 7'd60;
   localparam logic [OFFSET_W-1:0]   SWITCH_OFFSET_RST    = 4'd5;

   // degrees = (4*raw - 275) / 5, division by reciprocal 1639 / 2**13
   localparam logic signed [10:0] DEG_BIAS  = 11'sd275;
   localparam logic [10:0]        DEG_RECIP = 11'd1639;
   localparam int unsigned        DEG_SHIFT = 13;
   localparam logic signed [8:0]  DEG_CLAMP = 9'sd127;

endpackage : tab_pkg
`default_nettype wire

[rtl/thermostat_average_bang_bang.sv]
`default_nettype none
// A result is registered in the result registers after its request has
// passed the input register. Throughput: one request per cycle while
// rsp_ready is high; the input register takes one more request while a
// result waits on rsp_ready. Logic between the two registers does the update.
// Reset (synchronous, active high) turns the unit off, loads register
// defaults and leaves no result pending.
// ----------------------------------------------------------------------------
// thermostat_average_bang_bang
// Heater thermostat with windowed sample averaging and bang-bang drives.
// ----------------------------------------------------------------------------
module thermostat_average_bang_bang #(
   parameter int unsigned WINDOW_SAMPLES = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [tab_pkg::MODE_W-1:0]            req_mode,
   input  wire logic [tab_pkg::RAW_W-1:0]             req_sensor_raw,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_system_on,
   output logic                                       rsp_heater_on,
   output logic                                       rsp_cooler_on,
   output logic                                       rsp_indicator_led,
   output logic [tab_pkg::SETPOINT_W-1:0]             rsp_setpoint,
   output logic                                       rsp_decision_made,
   output logic signed [tab_pkg::TEMP_W-1:0]          rsp_average_temp,
   input  wire logic                                  csr_we,
   input  wire logic [tab_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [tab_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic [tab_pkg::COUNT_W-1:0] LAST_COUNT =
      tab_pkg::COUNT_W'(WINDOW_SAMPLES - 1);
   localparam int unsigned AVG_SHIFT = 16;
   localparam int unsigned AVG_RECIP_W = 17;
   localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
      AVG_RECIP_W'((2**AVG_SHIFT + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES);
   localparam int unsigned MAG_W = tab_pkg::SUM_W - 1;

   // configuration
   logic [tab_pkg::SETPOINT_W-1:0] sp_min_ff, sp_max_ff, sp_default_ff;
   logic [tab_pkg::STEP_W-1:0]     sp_step_ff;
   logic [tab_pkg::OFFSET_W-1:0]   offset_ff;

   // input register
   logic                            item_valid_ff, item_valid_in;
   tab_pkg::mode_type               item_mode_ff;
   logic signed [tab_pkg::TEMP_W-1:0] item_deg_ff, item_deg_in;

   // state and result
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              on_ff, on_in;
   logic [tab_pkg::SETPOINT_W-1:0]    sp_ff, sp_in;
   logic signed [tab_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [tab_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                              heater_ff, heater_in;
   logic                              cooler_ff, cooler_in;
   logic                              led_ff, led_in;
   logic signed [tab_pkg::TEMP_W-1:0] avg_ff, avg_in;
   logic                              decision_ff, decision_in;

   logic advance;

   // sample conversion ahead of the input register
   logic signed [10:0] deg_diff;
   logic [9:0]         deg_mag;
   logic [20:0]        deg_prod;
   logic signed [8:0]  deg_signed;

   // window average
   logic signed [tab_pkg::SUM_W-1:0]  sum_add;
   logic [MAG_W-1:0]                  sum_mag;
   logic [MAG_W+AVG_RECIP_W-1:0]      avg_prod;
   logic [tab_pkg::TEMP_W-1:0]        avg_q;
   logic signed [tab_pkg::TEMP_W-1:0] avg_now;
   logic signed [9:0]                 limit;
   logic signed [9:0]                 avg_ext;
   logic [tab_pkg::SETPOINT_W:0]      sp_up, sp_dn;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_comb begin
      deg_diff = $signed({1'b0, req_sensor_raw, 2'b00}) - tab_pkg::DEG_BIAS;
      deg_mag  = deg_diff[10] ? 10'(-deg_diff) : deg_diff[9:0];
      deg_prod = 21'(deg_mag) * 21'(tab_pkg::DEG_RECIP);
      deg_signed = deg_diff[10] ? -$signed({1'b0, deg_prod[tab_pkg::DEG_SHIFT +: 8]})
                                :  $signed({1'b0, deg_prod[tab_pkg::DEG_SHIFT +: 8]});
      item_deg_in = (deg_signed > tab_pkg::DEG_CLAMP) ? tab_pkg::TEMP_W'(tab_pkg::DEG_CLAMP)
                                                      : deg_signed[7:0];
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_ready) begin
         item_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sum_add  = sum_ff + {{(tab_pkg::SUM_W - tab_pkg::TEMP_W){item_deg_ff[7]}}, item_deg_ff};
      sum_mag  = sum_add[tab_pkg::SUM_W-1] ? MAG_W'(-sum_add) : sum_add[MAG_W-1:0];
      avg_prod = (MAG_W+AVG_RECIP_W)'(sum_mag) * (MAG_W+AVG_RECIP_W)'(AVG_RECIP);
      avg_q    = avg_prod[AVG_SHIFT +: tab_pkg::TEMP_W];
      avg_now  = sum_add[tab_pkg::SUM_W-1] ? -$signed(avg_q) : $signed(avg_q);
      avg_ext  = {{2{avg_now[7]}}, avg_now};
      limit    = $signed({3'b000, sp_ff}) + $signed({6'b000000, offset_ff});
      sp_up    = {1'b0, sp_ff} + {4'b0000, sp_step_ff};
      sp_dn    = {1'b0, sp_ff} - {4'b0000, sp_step_ff};

      on_in       = on_ff;
      sp_in       = sp_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      heater_in   = heater_ff;
      cooler_in   = cooler_ff;
      led_in      = led_ff;
      avg_in      = avg_ff;
      decision_in = 1'b0;

      unique case (item_mode_ff)
         tab_pkg::MODE_SAMPLE: begin
            if (on_ff) begin
               if (count_ff >= LAST_COUNT) begin
                  avg_in      = avg_now;
                  sum_in      = '0;
                  count_in    = '0;
                  decision_in = 1'b1;
                  if (avg_ext > limit) begin
                     heater_in = 1'b0;
                     cooler_in = 1'b1;
                     led_in    = 1'b1;
                  end else if (avg_ext < limit) begin
                     heater_in = 1'b1;
                     cooler_in = 1'b0;
                     led_in    = !led_ff;
                  end
               end else begin
                  sum_in   = sum_add;
                  count_in = count_ff + tab_pkg::COUNT_W'(1);
               end
            end
         end
         tab_pkg::MODE_UP: begin
            if (sp_ff < sp_max_ff) begin
               sp_in = sp_up[tab_pkg::SETPOINT_W] ? '1 : sp_up[tab_pkg::SETPOINT_W-1:0];
            end
         end
         tab_pkg::MODE_DOWN: begin
            if (sp_ff > sp_min_ff) begin
               sp_in = sp_dn[tab_pkg::SETPOINT_W] ? '0 : sp_dn[tab_pkg::SETPOINT_W-1:0];
            end
         end
         tab_pkg::MODE_TOGGLE: begin
            on_in  = !on_ff;
            sum_in = '0;
            if (sp_ff > sp_max_ff || sp_ff < sp_min_ff) begin
               sp_in = sp_default_ff;
            end
            if (on_ff) begin
               heater_in = 1'b0;
               cooler_in = 1'b0;
               led_in    = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_min_ff     <= tab_pkg::SETPOINT_MIN_RST;
         sp_max_ff     <= tab_pkg::SETPOINT_MAX_RST;
         sp_step_ff    <= tab_pkg::SETPOINT_STEP_RST;
         sp_default_ff <= tab_pkg::SETPOINT_DEFAULT_RST;
         offset_ff     <= tab_pkg::SWITCH_OFFSET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            tab_pkg::CSR_SETPOINT_MIN:     sp_min_ff     <= csr_wdata;
            tab_pkg::CSR_SETPOINT_MAX:     sp_max_ff     <= csr_wdata;
            tab_pkg::CSR_SETPOINT_STEP:    sp_step_ff    <= csr_wdata[tab_pkg::STEP_W-1:0];
            tab_pkg::CSR_SETPOINT_DEFAULT: sp_default_ff <= csr_wdata;
            tab_pkg::CSR_SWITCH_OFFSET:    offset_ff     <= csr_wdata[tab_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_mode_ff <= tab_pkg::MODE_SAMPLE;
         item_deg_ff  <= '0;
      end else if (req_valid && req_ready) begin
         item_mode_ff <= tab_pkg::mode_type'(req_mode);
         item_deg_ff  <= item_deg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         on_ff         <= 1'b0;
         sp_ff         <= tab_pkg::SETPOINT_DEFAULT_RST;
         sum_ff        <= '0;
         count_ff      <= '0;
         heater_ff     <= 1'b0;
         cooler_ff     <= 1'b0;
         led_ff        <= 1'b0;
         avg_ff        <= '0;
         decision_ff   <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            on_ff       <= on_in;
            sp_ff       <= sp_in;
            sum_ff      <= sum_in;
            count_ff    <= count_in;
            heater_ff   <= heater_in;
            cooler_ff   <= cooler_in;
            led_ff      <= led_in;
            avg_ff      <= avg_in;
            decision_ff <= decision_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_system_on     = on_ff;
   assign rsp_heater_on     = heater_ff;
   assign rsp_cooler_on     = cooler_ff;
   assign rsp_indicator_led = led_ff;
   assign rsp_setpoint      = sp_ff;
   assign rsp_decision_made = decision_ff;
   assign rsp_average_temp  = avg_ff;

endmodule : thermostat_average_bang_bang
`default_nettype wire

[rtl/tab_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tab_checker
// Port-level checks of the thermostat, bound to the top level.
// ----------------------------------------------------------------------------
module tab_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_system_on,
   input wire logic                              rsp_heater_on,
   input wire logic                              rsp_cooler_on,
   input wire logic                              rsp_indicator_led,
   input wire logic [tab_pkg::SETPOINT_W-1:0]    rsp_setpoint,
   input wire logic                              rsp_decision_made
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_setpoint)
                                  && $stable(rsp_system_on))
      else $error("stalled result changed");

   a_drive_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_heater_on && rsp_cooler_on))
      else $error("heater and cooler both driven");

   a_off_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_system_on |-> !rsp_heater_on && !rsp_cooler_on
                                      && !rsp_indicator_led && !rsp_decision_made)
      else $error("drive or decision while switched off");

endmodule : tab_checker

bind thermostat_average_bang_bang tab_checker u_tab_checker (.*);
`default_nettype wire
